// File: rtl/core/phase_to_waveform_sample_macros.svh
// ----------------------------------------------------------------------------
// Phase-to-waveform sample assertion macros
// Shorthand for clocked, reset-qualified properties used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PHASE_TO_WAVEFORM_SAMPLE_MACROS_SVH
`define PHASE_TO_WAVEFORM_SAMPLE_MACROS_SVH

// same-cycle implication
`define PTWS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ptws_pkg.sv
// ----------------------------------------------------------------------------
// Phase-to-waveform sample package
// Shared widths, waveform select codes and the elaboration-time quarter-wave
// sine table function.
// ----------------------------------------------------------------------------
package ptws_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ROM_W    = 15;
    localparam int PHASE_W  = 32;
    localparam int SEL_W    = 3;

    localparam real PI = 3.14159265358979323846;

    typedef enum logic [SEL_W-1:0] {
        WAVE_SINE_INTERP = 3'd0,
        WAVE_SINE        = 3'd1,
        WAVE_TRIANGLE    = 3'd2,
        WAVE_SQUARE      = 3'd3,
        WAVE_RAMP_UP     = 3'd4,
        WAVE_RAMP_DOWN   = 3'd5,
        WAVE_UNUSED_6    = 3'd6,
        WAVE_UNUSED_7    = 3'd7
    } t_wave;

    // Entry idx of a quarter-wave table with 2^tlog2 steps per quadrant:
    // round(32767 * sin(idx * pi / 2^(tlog2+1))). Called with constants only.
    function automatic logic [ROM_W-1:0] sine_entry(input int tlog2, input int idx);
        real ang;
        real val;
        int  k;
        ang = PI * real'(idx);
        // halving is exact, so this is the same angle as a power-of-two divide
        for (k = 0; k <= tlog2; k++) begin
            ang = ang * 0.5;
        end
        val = 32767.0 * $sin(ang) + 0.5;
        if (val > 32767.0) begin
            val = 32767.0;
        end
        return ROM_W'($rtoi(val));
    endfunction

endpackage

// File: rtl/core/ptws_rom.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// 2^TABLE_LOG2+1 entries, two read ports, registered read data, read enable.
// ----------------------------------------------------------------------------
module ptws_rom #(
    parameter int TABLE_LOG2 = 7
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [TABLE_LOG2:0]           i_addr_a,
    input  logic [TABLE_LOG2:0]           i_addr_b,
    output logic [ptws_pkg::ROM_W-1:0]    o_data_a,
    output logic [ptws_pkg::ROM_W-1:0]    o_data_b
);

    localparam int DEPTH = (1 << TABLE_LOG2) + 1;

    logic [ptws_pkg::ROM_W-1:0] rom [0:DEPTH-1];
    logic [ptws_pkg::ROM_W-1:0] r_data_a;
    logic [ptws_pkg::ROM_W-1:0] r_data_b;

    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        assign rom[g] = ptws_pkg::sine_entry(TABLE_LOG2, g);
    end

    // read data holds while the consuming stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= rom[i_addr_a];
            r_data_b <= rom[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

// File: rtl/core/phase_to_waveform_sample.sv
// ----------------------------------------------------------------------------
// Phase-to-waveform sample generator
// Maps a 32-bit phase and a waveform select to one signed 16-bit sample.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one beat per clock sustained when not stalled.
// Stages: a table read (both neighbor entries fetched in the same cycle from
// the two read ports of the quarter-wave ROM), a slope multiply, then the
// interpolation add into the output register. Each of the three stages
// advances on its own when the stage after it is empty or moving, so bubbles
// are squeezed out and a new beat is taken while a finished sample waits.
// Select codes: 0 interpolated sine, 1 sine, 2 triangle, 3 square,
// 4 ramp up, 5 ramp down; other codes give 0.
module phase_to_waveform_sample #(
    parameter int TABLE_LOG2 = 7,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [ptws_pkg::SEL_W-1:0]            i_req_type,
    input  logic [ptws_pkg::PHASE_W-1:0]          i_phase,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ptws_pkg::SAMPLE_W-1:0]  o_sample
);

    localparam int POS_W  = TABLE_LOG2 + 2;
    localparam int ADDR_W = TABLE_LOG2 + 1;
    localparam int DIFF_W = ptws_pkg::SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam logic [ADDR_W-1:0] QSTEPS = {1'b1, {TABLE_LOG2{1'b0}}};

    // stage handshake
    logic w_rdy1, w_rdy2, w_rdy3, w_accept;

    // stage 0 (address / direct waveforms)
    logic [POS_W-1:0]                      w_pos_a, w_pos_b;
    logic [ADDR_W-1:0]                     w_addr_a, w_addr_b;
    logic [FRAC_BITS-1:0]                  w_frac;
    logic signed [ptws_pkg::SAMPLE_W-1:0]  w_alt;

    // stage 1 registers
    logic                                  r1_valid;
    logic                                  r1_sine, r1_interp;
    logic                                  r1_neg_a, r1_neg_b;
    logic [FRAC_BITS-1:0]                  r1_frac;
    logic signed [ptws_pkg::SAMPLE_W-1:0]  r1_alt;
    logic [ptws_pkg::ROM_W-1:0]            w_rom_a, w_rom_b;

    // stage 1 logic
    logic signed [ptws_pkg::SAMPLE_W-1:0]  w_mag_a, w_mag_b, w_s_a, w_s_b;
    logic signed [DIFF_W-1:0]              w_diff;
    logic signed [FRAC_BITS:0]             w_frac_s;
    logic signed [PROD_W-1:0]              w_prod;

    // stage 2 registers
    logic                                  r2_valid;
    logic                                  r2_interp;
    logic signed [ptws_pkg::SAMPLE_W-1:0]  r2_base;
    logic signed [PROD_W-1:0]              r2_prod;

    // stage 2 logic
    logic signed [PROD_W-1:0]              w_shift;
    logic signed [ptws_pkg::SAMPLE_W-1:0]  n_sample;

    // output register
    logic                                  r_out_valid;
    logic signed [ptws_pkg::SAMPLE_W-1:0]  r_sample;

    assign w_rdy3     = !r_out_valid || i_out_ready;
    assign w_rdy2     = !r2_valid || w_rdy3;
    assign w_rdy1     = !r1_valid || w_rdy2;
    assign o_in_ready = w_rdy1;
    assign w_accept   = i_in_valid && w_rdy1;

    // table positions: quadrant on top, index below; odd quadrants mirror
    always_comb begin
        w_pos_a = i_phase[ptws_pkg::PHASE_W-1 -: POS_W];
        w_pos_b = w_pos_a + POS_W'(1);
        w_frac  = i_phase[ptws_pkg::PHASE_W-1-POS_W -: FRAC_BITS];
        if (w_pos_a[TABLE_LOG2]) begin
            w_addr_a = QSTEPS - {1'b0, w_pos_a[TABLE_LOG2-1:0]};
        end else begin
            w_addr_a = {1'b0, w_pos_a[TABLE_LOG2-1:0]};
        end
        if (w_pos_b[TABLE_LOG2]) begin
            w_addr_b = QSTEPS - {1'b0, w_pos_b[TABLE_LOG2-1:0]};
        end else begin
            w_addr_b = {1'b0, w_pos_b[TABLE_LOG2-1:0]};
        end
    end

    // waveforms taken straight from the phase bits
    always_comb begin
        case (i_req_type)
            ptws_pkg::WAVE_TRIANGLE: begin
                case (i_phase[31:30])
                    2'd0:    w_alt = {1'b0, i_phase[29:15]};
                    2'd1:    w_alt = {1'b0, ~i_phase[29:15]};
                    2'd2:    w_alt = -$signed({1'b0, i_phase[29:15]});
                    default: w_alt = {1'b1, i_phase[29:15]};
                endcase
            end
            ptws_pkg::WAVE_SQUARE: begin
                w_alt = i_phase[31] ? 16'sh7FFF : 16'sh8000;
            end
            ptws_pkg::WAVE_RAMP_UP: begin
                w_alt = i_phase[31] ? 16'sh7FFF : {1'b0, i_phase[30:16]};
            end
            ptws_pkg::WAVE_RAMP_DOWN: begin
                w_alt = i_phase[31] ? 16'sh0000 : {1'b0, ~i_phase[30:16]};
            end
            default: begin
                w_alt = '0;
            end
        endcase
    end

    ptws_rom #(
        .TABLE_LOG2 (TABLE_LOG2)
    ) u_rom (
        .i_clk    (i_clk),
        .i_en     (w_accept),
        .i_addr_a (w_addr_a),
        .i_addr_b (w_addr_b),
        .o_data_a (w_rom_a),
        .o_data_b (w_rom_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_rdy1) begin
            r1_valid <= i_in_valid;
        end
        if (w_accept) begin
            r1_sine   <= (i_req_type == ptws_pkg::WAVE_SINE_INTERP) ||
                         (i_req_type == ptws_pkg::WAVE_SINE);
            r1_interp <= (i_req_type == ptws_pkg::WAVE_SINE_INTERP);
            r1_neg_a  <= w_pos_a[POS_W-1];
            r1_neg_b  <= w_pos_b[POS_W-1];
            r1_frac   <= w_frac;
            r1_alt    <= w_alt;
        end
    end

    // signed neighbor samples and the slope product
    always_comb begin
        w_mag_a  = $signed({1'b0, w_rom_a});
        w_mag_b  = $signed({1'b0, w_rom_b});
        w_s_a    = r1_neg_a ? -w_mag_a : w_mag_a;
        w_s_b    = r1_neg_b ? -w_mag_b : w_mag_b;
        w_diff   = DIFF_W'(w_s_b) - DIFF_W'(w_s_a);
        w_frac_s = $signed({1'b0, r1_frac});
        w_prod   = PROD_W'(w_diff) * PROD_W'(w_frac_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_rdy2) begin
            r2_valid <= r1_valid;
        end
        if (w_rdy2 && r1_valid) begin
            r2_interp <= r1_interp;
            r2_base   <= r1_sine ? w_s_a : r1_alt;
            r2_prod   <= w_prod;
        end
    end

    // floor shift; the sum lies between the two neighbors, so 16 bits hold it
    always_comb begin
        w_shift  = r2_prod >>> FRAC_BITS;
        n_sample = r2_interp ? r2_base + ptws_pkg::SAMPLE_W'(w_shift) : r2_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy3) begin
            r_out_valid <= r2_valid;
        end
        if (w_rdy3 && r2_valid) begin
            r_sample <= n_sample;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

endmodule

// File: rtl/core/ptws_checker.sv
// ----------------------------------------------------------------------------
// Phase-to-waveform sample port checker
// Watches the top-level ports for stream and occupancy consistency.
// ----------------------------------------------------------------------------
`include "phase_to_waveform_sample_macros.svh"

module ptws_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_ready,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic signed [ptws_pkg::SAMPLE_W-1:0]  o_sample
);

    // beats inside the block: at most one per stage
    logic [2:0] r_cnt;
    logic       w_in_beat, w_out_beat;

    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_out_beat = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_beat && !w_out_beat) begin
            r_cnt <= r_cnt + 3'd1;
        end else if (w_out_beat && !w_in_beat) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    `PTWS_ASSERT_NEXT(a_out_valid_hold, o_out_valid && !i_out_ready, o_out_valid, "output valid dropped while stalled")
    `PTWS_ASSERT_NEXT(a_out_data_hold, o_out_valid && !i_out_ready, $stable(o_sample), "output sample changed while stalled")
    `PTWS_ASSERT_NOW(a_no_phantom, o_out_valid, r_cnt != 3'd0, "output beat with no input beat in flight")
    `PTWS_ASSERT_NOW(a_capacity, 1'b1, r_cnt <= 3'd3, "more beats in flight than pipeline stages")
    `PTWS_ASSERT_NOW(a_empty_ready, r_cnt == 3'd0, o_in_ready, "empty block not ready for input")

endmodule

bind phase_to_waveform_sample ptws_checker u_ptws_checker (.*);
